### rtl/mandelbrot_escape_time_macros.svh
// Assertion macros used by the checker file of the escape-time block.
// Each macro expects the signals i_clk and i_rst_n in the enclosing scope.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

    localparam int FRAC_BITS = 60;
    localparam int ITER_BITS = 13;
    localparam int IN_BITS   = 63;
    localparam int WORD_BITS = 64;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int PROD_BITS = 2 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] t_fx;
    typedef logic        [WORD_BITS-1:0] t_mag;
    typedef logic        [PROD_BITS-1:0] t_prod;
    typedef logic        [ITER_BITS-1:0] t_iter;

    localparam t_fx FX_MAX         = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_fx FX_MIN         = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_fx FX_ONE         = t_fx'(1) <<< FRAC_BITS;
    localparam t_fx FX_QUARTER     = t_fx'(1) <<< (FRAC_BITS - 2);
    localparam t_fx FX_SIXTEENTH   = t_fx'(1) <<< (FRAC_BITS - 4);
    localparam t_fx FX_FOUR        = t_fx'(1) <<< (FRAC_BITS + 2);
    localparam t_fx FX_NEG_QUARTER = -FX_QUARTER;

    localparam t_iter LIMIT_RESET = t_iter'(128);

    typedef enum logic [2:0] {
        MUL_CI2,
        MUL_PP,
        MUL_QQP,
        MUL_RHS,
        MUL_BULB,
        MUL_ZI,
        MUL_ZR2,
        MUL_ZI2
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    mul_start;
        t_mul_op mul_op;
        logic    diff_en;
        logic    z_step;
        logic    it_set_limit;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic in_region;
        logic loop_go;
    } t_sts;

    // Signed add that clamps to the word range instead of wrapping.
    function automatic t_fx sat_add(input t_fx a, input t_fx b);
        logic signed [WORD_BITS:0] s;
        t_fx r;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            r = s[WORD_BITS] ? FX_MIN : FX_MAX;
        end else begin
            r = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/mbe_fxmul.sv
`default_nettype none

module mbe_fxmul import mbe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_fx  i_a,
    input  wire t_fx  i_b,
    output logic      o_done,
    output t_fx       o_p
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_ABS,
        M_PROD,
        M_LAST,
        M_FIN
    } t_mstate;

    localparam logic [1:0] STEP_LAST = '1;

    t_mstate    r_state;
    t_mstate    n_state;
    logic       r_done;
    logic [1:0] r_step;
    logic [1:0] r_pp_step;
    logic       r_pp_vld;
    logic       r_neg;
    t_mag       r_x;
    t_mag       r_y;
    t_mag       r_pp;
    t_prod      r_acc;
    t_fx        r_p;

    logic [HALF_BITS-1:0] xs;
    logic [HALF_BITS-1:0] ys;
    t_mag                 pp_next;
    t_prod                pp_shifted;
    logic                 ovf;
    logic                 rem_nz;
    t_mag                 qm;
    t_fx                  fin;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_state = M_ABS;
                end
            end
            M_ABS:  n_state = M_PROD;
            M_PROD: begin
                if (r_step == STEP_LAST) begin
                    n_state = M_LAST;
                end
            end
            M_LAST: n_state = M_FIN;
            M_FIN:  n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_FIN);
            r_step  <= (r_state == M_PROD) ? r_step + 2'd1 : '0;
        end
    end

    always_comb begin
        xs      = r_step[1] ? r_x[WORD_BITS-1:HALF_BITS] : r_x[HALF_BITS-1:0];
        ys      = r_step[0] ? r_y[WORD_BITS-1:HALF_BITS] : r_y[HALF_BITS-1:0];
        pp_next = xs * ys;
    end

    always_comb begin
        case (r_pp_step) inside
            2'd0:       pp_shifted = t_prod'(r_pp);
            2'd1, 2'd2: pp_shifted = t_prod'(r_pp) << HALF_BITS;
            default:    pp_shifted = t_prod'(r_pp) << WORD_BITS;
        endcase
    end

    // The product magnitude is floored toward minus infinity for negative results.
    always_comb begin
        ovf    = |r_acc[PROD_BITS-1:WORD_BITS+FRAC_BITS];
        qm     = r_acc[WORD_BITS+FRAC_BITS-1:FRAC_BITS];
        rem_nz = |r_acc[FRAC_BITS-1:0];
        if (!r_neg) begin
            fin = (ovf || qm[WORD_BITS-1]) ? FX_MAX : t_fx'(qm);
        end else if (ovf || qm[WORD_BITS-1] || (rem_nz && (&qm[WORD_BITS-2:0]))) begin
            fin = FX_MIN;
        end else begin
            fin = t_fx'(~qm) + t_fx'({{(WORD_BITS-1){1'b0}}, !rem_nz});
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    r_x   <= i_a;
                    r_y   <= i_b;
                    r_neg <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
                end
            end
            M_ABS: begin
                r_x      <= r_x[WORD_BITS-1] ? t_mag'(0) - r_x : r_x;
                r_y      <= r_y[WORD_BITS-1] ? t_mag'(0) - r_y : r_y;
                r_acc    <= '0;
                r_pp_vld <= 1'b0;
            end
            M_PROD: begin
                r_pp      <= pp_next;
                r_pp_step <= r_step;
                r_pp_vld  <= 1'b1;
                if (r_pp_vld) begin
                    r_acc <= r_acc + pp_shifted;
                end
            end
            M_LAST: begin
                r_acc <= r_acc + pp_shifted;
            end
            M_FIN: begin
                r_p <= fin;
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

`default_nettype wire

### rtl/mbe_datapath.sv
`default_nettype none

module mbe_datapath import mbe_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire t_iter                      i_cfg_wdata,
    input  wire logic signed [IN_BITS-1:0]  i_c_re,
    input  wire logic signed [IN_BITS-1:0]  i_c_im,
    input  wire t_cmd                       i_cmd,
    output t_sts                            o_sts,
    output t_iter                           o_iterations,
    output logic                            o_in_set
);

    t_iter   r_limit;
    t_iter   r_it;
    t_mul_op r_op;
    t_fx     r_cr;
    t_fx     r_ci;
    t_fx     r_p;
    t_fx     r_r1;
    t_fx     r_ci2;
    t_fx     r_q;
    t_fx     r_lhs;
    t_fx     r_rhs;
    t_fx     r_bulb;
    t_fx     r_zr;
    t_fx     r_zi;
    t_fx     r_zr2;
    t_fx     r_zi2;
    t_fx     r_d;
    t_iter   r_iterations;
    logic    r_in_set;

    t_fx  c_re_fx;
    t_fx  mul_a;
    t_fx  mul_b;
    t_fx  mul_p;
    logic mul_done;

    assign c_re_fx = t_fx'(i_c_re);

    always_comb begin
        unique case (i_cmd.mul_op)
            MUL_CI2: begin
                mul_a = r_ci;
                mul_b = r_ci;
            end
            MUL_PP: begin
                mul_a = r_p;
                mul_b = r_p;
            end
            MUL_QQP: begin
                mul_a = r_q;
                mul_b = sat_add(r_q, r_p);
            end
            MUL_RHS: begin
                mul_a = r_ci >>> 2;
                mul_b = r_ci;
            end
            MUL_BULB: begin
                mul_a = r_r1;
                mul_b = r_r1;
            end
            MUL_ZI: begin
                mul_a = sat_add(r_zr, r_zr);
                mul_b = r_zi;
            end
            MUL_ZR2: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
            MUL_ZI2: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            default: begin
                mul_a = r_ci;
                mul_b = r_ci;
            end
        endcase
    end

    mbe_fxmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr  <= c_re_fx;
            r_ci  <= t_fx'(i_c_im);
            r_p   <= sat_add(c_re_fx, FX_NEG_QUARTER);
            r_r1  <= sat_add(c_re_fx, FX_ONE);
            r_zr  <= '0;
            r_zi  <= '0;
            r_zr2 <= '0;
            r_zi2 <= '0;
            r_it  <= '0;
        end
        if (i_cmd.mul_start) begin
            r_op <= i_cmd.mul_op;
        end
        if (mul_done) begin
            unique case (r_op)
                MUL_CI2:  r_ci2  <= mul_p;
                MUL_PP:   r_q    <= sat_add(mul_p, r_ci2);
                MUL_QQP:  r_lhs  <= mul_p;
                MUL_RHS:  r_rhs  <= mul_p;
                MUL_BULB: r_bulb <= sat_add(mul_p, r_ci2);
                MUL_ZI:   r_zi   <= sat_add(mul_p, r_ci);
                MUL_ZR2:  r_zr2  <= mul_p;
                MUL_ZI2:  r_zi2  <= mul_p;
                default:  r_zi2  <= mul_p;
            endcase
        end
        if (i_cmd.diff_en) begin
            r_d <= sat_add(r_zr2, -r_zi2);
        end
        if (i_cmd.z_step) begin
            r_zr <= sat_add(r_d, r_cr);
            r_it <= r_it + t_iter'(1);
        end
        if (i_cmd.it_set_limit) begin
            r_it <= r_limit;
        end
        if (i_cmd.out_load) begin
            r_iterations <= r_it;
            r_in_set     <= (r_it == r_limit);
        end
    end

    always_comb begin
        o_sts.mul_done  = mul_done;
        o_sts.in_region = (r_lhs <= r_rhs) || (r_bulb <= FX_SIXTEENTH);
        o_sts.loop_go   = (sat_add(r_zr2, r_zi2) < FX_FOUR) && (r_it < r_limit);
    end

    assign o_iterations = r_iterations;
    assign o_in_set     = r_in_set;

endmodule

`default_nettype wire

### rtl/mbe_ctrl.sv
`default_nettype none

module mbe_ctrl import mbe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CI2,
        S_PP,
        S_QQP,
        S_RHS,
        S_BULB,
        S_CLASSIFY,
        S_CHECK,
        S_ZI,
        S_ZR2,
        S_ZI2,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_go;
    logic   n_go;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    always_comb begin
        n_state  = r_state;
        n_go     = 1'b0;
        out_free = !r_out_valid || i_out_ready;
        o_cmd    = '0;
        o_cmd.mul_op    = MUL_CI2;
        o_cmd.mul_start = r_go;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CI2;
                    n_go       = 1'b1;
                end
            end
            S_CI2: begin
                o_cmd.mul_op = MUL_CI2;
                if (i_sts.mul_done) begin
                    n_state = S_PP;
                    n_go    = 1'b1;
                end
            end
            S_PP: begin
                o_cmd.mul_op = MUL_PP;
                if (i_sts.mul_done) begin
                    n_state = S_QQP;
                    n_go    = 1'b1;
                end
            end
            S_QQP: begin
                o_cmd.mul_op = MUL_QQP;
                if (i_sts.mul_done) begin
                    n_state = S_RHS;
                    n_go    = 1'b1;
                end
            end
            S_RHS: begin
                o_cmd.mul_op = MUL_RHS;
                if (i_sts.mul_done) begin
                    n_state = S_BULB;
                    n_go    = 1'b1;
                end
            end
            S_BULB: begin
                o_cmd.mul_op = MUL_BULB;
                if (i_sts.mul_done) begin
                    n_state = S_CLASSIFY;
                end
            end
            S_CLASSIFY: begin
                if (i_sts.in_region) begin
                    o_cmd.it_set_limit = 1'b1;
                    n_state            = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.diff_en = 1'b1;
                if (i_sts.loop_go) begin
                    n_state = S_ZI;
                    n_go    = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ZI: begin
                o_cmd.mul_op = MUL_ZI;
                o_cmd.z_step = r_go;
                if (i_sts.mul_done) begin
                    n_state = S_ZR2;
                    n_go    = 1'b1;
                end
            end
            S_ZR2: begin
                o_cmd.mul_op = MUL_ZR2;
                if (i_sts.mul_done) begin
                    n_state = S_ZI2;
                    n_go    = 1'b1;
                end
            end
            S_ZI2: begin
                o_cmd.mul_op = MUL_ZI2;
                if (i_sts.mul_done) begin
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/mandelbrot_escape_time.sv
// Escape-time counter for one point c of the complex plane, in signed Q3.60.
// Input channel: i_in_valid / o_in_ready carry i_c_re and i_c_im. An item is
// taken when both are high. Output channel: o_out_valid / i_out_ready carry
// o_iterations and o_in_set, held in an output register.
// Configuration: i_cfg_we writes i_cfg_wdata into the iteration limit. Write
// it only while no item is in flight.
// The block works on one item at a time. All products go through a single
// 32 x 32 multiplier that forms a 64 x 64 product over four partial steps.
// The cardioid and bulb tests use five products. Each iteration uses three
// products plus one check state.
// After a result is written to the output register the next item is taken
// at once. If the receiver stalls, that item is computed in full and then
// waits until the output register is free.
// Reset clears both channels and sets the limit to 128.
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire t_iter                     i_cfg_wdata,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic signed [IN_BITS-1:0] i_c_re,
    input  wire logic signed [IN_BITS-1:0] i_c_im,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output t_iter                          o_iterations,
    output logic                           o_in_set
);

    t_cmd cmd;
    t_sts sts;

    mbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mbe_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_c_re       (i_c_re),
        .i_c_im       (i_c_im),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_iterations (o_iterations),
        .o_in_set     (o_in_set)
    );

endmodule

`default_nettype wire

### rtl/mbe_checker.sv
`default_nettype none

`include "mandelbrot_escape_time_macros.svh"

module mbe_checker import mbe_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_cfg_we,
    input wire t_iter i_cfg_wdata,
    input wire logic  i_in_valid,
    input wire logic  i_in_ready,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_iter i_iterations,
    input wire logic  i_in_set
);

    t_iter r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_lim <= i_cfg_wdata;
        end
    end

    `MBE_ASSERT_NOW(a_in_set_flag, i_out_valid, i_in_set == (i_iterations == r_lim), "in_set does not match the count")
    `MBE_ASSERT_NOW(a_count_bound, i_out_valid, i_iterations <= r_lim, "count exceeds the limit")
    `MBE_ASSERT_NEXT(a_busy_after_take, i_in_valid && i_in_ready, !i_in_ready, "ready stayed high after an item was taken")
    `MBE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_iterations) && $stable(i_in_set), "stalled result changed")

endmodule

bind mandelbrot_escape_time mbe_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_we     (i_cfg_we),
    .i_cfg_wdata  (i_cfg_wdata),
    .i_in_valid   (i_in_valid),
    .i_in_ready   (o_in_ready),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_iterations (o_iterations),
    .i_in_set     (o_in_set)
);

`default_nettype wire

### tb/mandelbrot_escape_time_test.sv
`default_nettype none

module mandelbrot_escape_time_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbe_pkg::*;

    localparam int          FRAC           = 60;
    localparam int          SEG_COUNT      = 16;
    localparam int          ITEMS_PER_SEG  = 84;
    localparam int unsigned WATCHDOG_LIMIT = 1_000_000;
    localparam int unsigned FAR_ONLY_ABOVE = 1000;
    localparam t_iter       LIMIT_AT_RESET = 13'd128;
    localparam longint      GRID_STEP      = 64'sd1152921504606846;

    localparam t_fx TOP_FX       = {1'b0, {63{1'b1}}};
    localparam t_fx BOTTOM_FX    = {1'b1, {63{1'b0}}};
    localparam t_fx ONE_FX       = t_fx'(1) <<< FRAC;
    localparam t_fx QUARTER_FX   = t_fx'(1) <<< (FRAC - 2);
    localparam t_fx SIXTEENTH_FX = t_fx'(1) <<< (FRAC - 4);
    localparam t_fx FOUR_FX      = t_fx'(1) <<< (FRAC + 2);

    localparam logic signed [62:0] IN_TOP    = {1'b0, {62{1'b1}}};
    localparam logic signed [62:0] IN_BOTTOM = {1'b1, {62{1'b0}}};

    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } t_flow;

    typedef struct packed {
        t_iter iterations;
        logic  in_set;
    } t_escape_result;

    class t_escape_board;
        t_iter          limit;
        t_escape_result expected_q[$];
        int             failures;

        function new();
            limit    = LIMIT_AT_RESET;
            failures = 0;
        endfunction

        function void set_limit(t_iter value);
            limit = value;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function t_fx clamp_add(t_fx a, t_fx b);
            logic signed [64:0] s;
            s = a + b;
            if (s > TOP_FX) return TOP_FX;
            if (s < BOTTOM_FX) return BOTTOM_FX;
            return s[63:0];
        endfunction

        function t_fx fixed_mul(t_fx a, t_fx b);
            logic signed [127:0] p;
            p = a * b;
            p = p >>> FRAC;
            if (p > TOP_FX) return TOP_FX;
            if (p < BOTTOM_FX) return BOTTOM_FX;
            return p[63:0];
        endfunction

        function int unsigned escape_count(t_fx cr, t_fx ci);
            t_fx         p, ci2, q, lhs, rhs, r1, bulb;
            t_fx         zr, zi, zr2, zi2;
            int unsigned n;
            p    = clamp_add(cr, -QUARTER_FX);
            ci2  = fixed_mul(ci, ci);
            q    = clamp_add(fixed_mul(p, p), ci2);
            lhs  = fixed_mul(q, clamp_add(q, p));
            rhs  = fixed_mul(fixed_mul(QUARTER_FX, ci), ci);
            r1   = clamp_add(cr, ONE_FX);
            bulb = clamp_add(fixed_mul(r1, r1), ci2);
            if (lhs <= rhs || bulb <= SIXTEENTH_FX) return limit;
            zr  = '0;
            zi  = '0;
            zr2 = '0;
            zi2 = '0;
            n   = 0;
            while (clamp_add(zr2, zi2) < FOUR_FX && n < limit) begin
                zi  = clamp_add(fixed_mul(clamp_add(zr, zr), zi), ci);
                zr  = clamp_add(clamp_add(zr2, -zi2), cr);
                zr2 = fixed_mul(zr, zr);
                zi2 = fixed_mul(zi, zi);
                n++;
            end
            return n;
        endfunction

        function void note_point(logic signed [62:0] re, logic signed [62:0] im);
            int unsigned n;
            n = escape_count({re[62], re}, {im[62], im});
            expected_q.push_back(t_escape_result'{t_iter'(n), n == limit});
        endfunction

        function void check_result(t_iter got_iterations, logic got_in_set);
            t_escape_result want;
            if (expected_q.size() == 0) begin
                $error("Result with no item outstanding: iterations %0d, in_set %0d",
                       got_iterations, got_in_set);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got_iterations !== want.iterations) begin
                $error("iterations: expected %0d, actual %0d", want.iterations, got_iterations);
                failures++;
            end
            if (got_in_set !== want.in_set) begin
                $error("in_set: expected %0d, actual %0d", want.in_set, got_in_set);
                failures++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    t_iter             cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    logic signed [62:0] c_re     = '0;
    logic signed [62:0] c_im     = '0;
    logic              out_ready = 1'b0;
    logic              in_ready;
    logic              out_valid;
    t_iter             iterations;
    logic              in_set;

    int            idle_pct     = 0;
    int            stall_pct    = 0;
    int unsigned   quiet_cycles = 0;
    t_escape_board board;

    t_iter seg_limits [SEG_COUNT] = '{
        13'd1, 13'd31, 13'd128, 13'd8191, 13'd2, 13'd64, 13'd255, 13'd7,
        13'd100, 13'd3, 13'd16, 13'd200, 13'd47, 13'd11, 13'd90, 13'd24
    };

    mandelbrot_escape_time dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_c_re       (c_re),
        .i_c_im       (c_im),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_iterations (iterations),
        .o_in_set     (in_set)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            board.check_result(iterations, in_set);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic signed [62:0] to_fx(real r);
        return 63'(longint'(r * (2.0 ** FRAC)));
    endfunction

    task automatic send_point(input logic signed [62:0] re, input logic signed [62:0] im);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        c_re     <= re;
        c_im     <= im;
        do @(posedge clk); while (!in_ready);
        board.note_point(re, im);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input t_iter value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_limit(value);
    endtask

    initial begin
        int                 seg;
        int                 k;
        int                 kind;
        bit                 far_only;
        logic signed [62:0] re;
        logic signed [62:0] im;

        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The reset limit is exercised before any write.
        send_point(to_fx(0.0), to_fx(0.0));
        send_point(to_fx(-1.0), to_fx(0.0));
        send_point(to_fx(0.25), to_fx(0.0));
        send_point(to_fx(-1.25), to_fx(0.0));
        send_point(to_fx(-0.75), to_fx(0.0));
        send_point(to_fx(0.0), to_fx(1.0));
        send_point(to_fx(0.3), to_fx(0.0));
        send_point(to_fx(-0.75), to_fx(0.1));
        send_point(to_fx(2.0), to_fx(0.0));
        send_point(to_fx(-2.0), to_fx(0.0));
        send_point(IN_TOP, IN_TOP);
        send_point(IN_BOTTOM, IN_BOTTOM);
        send_point(IN_BOTTOM, IN_TOP);
        send_point(IN_TOP, IN_BOTTOM);
        send_point(63'sd1, -63'sd1);
        send_point(to_fx(-0.1226), to_fx(0.7449));
        send_point(to_fx(0.5), to_fx(0.5));
        drain();

        write_limit(13'd1);
        send_point(to_fx(0.0), to_fx(0.0));
        send_point(to_fx(0.3), to_fx(0.0));
        send_point(to_fx(3.0), to_fx(3.0));
        drain();

        write_limit(13'd0);
        send_point(to_fx(0.0), to_fx(0.0));
        send_point(to_fx(3.0), to_fx(0.0));
        drain();

        write_limit(13'd8191);
        send_point(to_fx(0.0), to_fx(0.0));
        send_point(to_fx(0.0), to_fx(1.0));
        send_point(IN_TOP, to_fx(0.0));
        drain();

        for (seg = 0; seg < SEG_COUNT; seg++) begin
            case (t_flow'(seg % 4))
                FLOW_FREE: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                FLOW_SENDER_IDLE: begin
                    idle_pct  = 71;
                    stall_pct = 0;
                end
                FLOW_RECEIVER_STALL: begin
                    idle_pct  = 0;
                    stall_pct = 71;
                end
                default: begin
                    idle_pct  = 28;
                    stall_pct = 28;
                end
            endcase
            write_limit(seg_limits[seg]);
            // With a very high limit only points that escape at once keep the run short.
            far_only = (seg_limits[seg] > FAR_ONLY_ABOVE);
            for (k = 0; k < ITEMS_PER_SEG; k++) begin
                kind = $urandom_range(9);
                if (far_only || kind < 3) begin
                    re = 63'({$urandom, $urandom});
                    im = 63'({$urandom, $urandom});
                    if (far_only) begin
                        re[61] = ~re[62];
                    end
                end else begin
                    re = 63'((longint'($urandom_range(0, 2500)) - 2000) * GRID_STEP
                             + longint'({$urandom_range(0, 262143), $urandom}));
                    im = 63'((longint'($urandom_range(0, 2500)) - 1250) * GRID_STEP
                             + longint'({$urandom_range(0, 262143), $urandom}));
                end
                send_point(re, im);
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (board.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
